// ----- rtl/nsd_pkg.sv -----
package nsd_pkg;

	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 20;
	localparam int ACCUM_W = 30;

	localparam logic [LEN_W-1:0]  HARD_MAX_LENGTH = 20'd1000000;
	localparam logic [BYTE_W-1:0] CHAR_COLON      = 8'h3A;
	localparam logic [BYTE_W-1:0] CHAR_COMMA      = 8'h2C;
	localparam logic [BYTE_W-1:0] CHAR_ZERO       = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_NINE       = 8'h39;

	typedef enum logic [1:0] {
		PH_PREFIX  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_COMMA   = 2'd2,
		PH_ERROR   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] data;
		logic [LEN_W-1:0]  length;
	} result_t;

endpackage

// ----- rtl/nsd_core.sv -----
module nsd_core #(
	parameter int MAX_PREFIX_BYTES = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             data_in,
	input  logic [19:0]            limit,
	output logic                   res_valid,
	output nsd_pkg::result_t       res
);
	import nsd_pkg::*;

	localparam int CW = (MAX_PREFIX_BYTES > 1) ? $clog2(MAX_PREFIX_BYTES) : 1;

	phase_t             phase_q, phase_d;
	logic [ACCUM_W-1:0] accum_q, accum_d;
	logic [CW-1:0]      count_q, count_d;
	logic [LEN_W-1:0]   left_q, left_d;

	logic               is_colon, is_comma, is_digit, over_limit, prefix_full;
	logic [ACCUM_W-1:0] accum_next;
	logic [LEN_W-1:0]   left_dec;

	assign is_colon    = (data_in == CHAR_COLON);
	assign is_comma    = (data_in == CHAR_COMMA);
	assign is_digit    = (data_in >= CHAR_ZERO) && (data_in <= CHAR_NINE);
	assign over_limit  = (accum_q > {{(ACCUM_W-LEN_W){1'b0}}, limit});
	assign prefix_full = (count_q >= CW'(MAX_PREFIX_BYTES - 1));
	// Times ten as two shifted copies plus the new digit.
	assign accum_next  = {accum_q[ACCUM_W-4:0], 3'b000} + {accum_q[ACCUM_W-2:0], 1'b0}
		+ {{(ACCUM_W-BYTE_W){1'b0}}, data_in - CHAR_ZERO};
	assign left_dec    = left_q - LEN_W'(1);

	always_comb begin
		phase_d = phase_q;
		accum_d = accum_q;
		count_d = count_q;
		left_d  = left_q;
		if (step) begin
			unique case (phase_q)
				PH_PREFIX: begin
					if (is_colon) begin
						if (over_limit) begin
							phase_d = PH_ERROR;
						end else begin
							left_d  = accum_q[LEN_W-1:0];
							phase_d = (accum_q[LEN_W-1:0] == '0) ? PH_COMMA : PH_PAYLOAD;
						end
					end else if (prefix_full || !is_digit) begin
						phase_d = PH_ERROR;
					end else begin
						accum_d = accum_next;
						count_d = count_q + CW'(1);
					end
				end
				PH_PAYLOAD: begin
					left_d = left_dec;
					if (left_dec == '0) begin
						phase_d = PH_COMMA;
					end
				end
				PH_COMMA: begin
					if (!is_comma) begin
						phase_d = PH_ERROR;
					end else begin
						phase_d = PH_PREFIX;
						accum_d = '0;
						count_d = '0;
						left_d  = '0;
					end
				end
				PH_ERROR: begin
					phase_d = PH_ERROR;
				end
				default: begin
					phase_d = PH_ERROR;
				end
			endcase
		end
	end

	always_comb begin
		res_valid  = 1'b0;
		res.kind   = KIND_ERROR;
		res.data   = '0;
		res.length = '0;
		if (step) begin
			unique case (phase_q)
				PH_PREFIX: begin
					res_valid = is_colon ? over_limit : (prefix_full || !is_digit);
				end
				PH_PAYLOAD: begin
					res_valid = 1'b1;
					res.kind  = KIND_DATA;
					res.data  = data_in;
				end
				PH_COMMA: begin
					res_valid = 1'b1;
					if (is_comma) begin
						res.kind   = KIND_DONE;
						res.length = accum_q[LEN_W-1:0];
					end
				end
				PH_ERROR: begin
					res_valid = 1'b0;
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX;
			accum_q <= '0;
			count_q <= '0;
			left_q  <= '0;
		end else begin
			phase_q <= phase_d;
			accum_q <= accum_d;
			count_q <= count_d;
			left_q  <= left_d;
		end
	end

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR |=> phase_q == PH_ERROR)
		else $error("error phase left before reset");

	a_error_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR |-> !res_valid)
		else $error("result produced in error phase");

	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> left_q != '0)
		else $error("payload phase with no bytes left");

endmodule

// ----- rtl/netstring_deframer.sv -----
// Channel | Direction | Handshake           | Beat contents
// --------+-----------+---------------------+------------------------------------
// in      | input     | in_valid / in_ready | in_byte: one stream byte
// out     | output    | out_valid/out_ready | kind, out_byte, message_length
// cfg     | input     | cfg_valid/cfg_ready | cfg_data: max_length (20 bits)
//
// One input beat can be taken every cycle. A byte is decoded combinationally in
// the cycle it is accepted, and its result, if any, is in the output register
// right after that edge. The input is ready when the output register is empty or
// being drained, so a held result stalls the input only while out_ready is low.
// Reset puts the decoder in the prefix phase with a zero length and max_length at
// 1000000. Configuration is always ready; a write applies to the bytes after it.
module netstring_deframer #(
	parameter int MAX_PREFIX_BYTES = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [19:0] message_length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [19:0] cfg_data
);
	import nsd_pkg::*;

	// The length limit is kept already saturated to the hard maximum, since
	// only the saturated value is ever compared against.
	logic [LEN_W-1:0] limit_q;

	logic    step;
	logic    res_valid;
	result_t res;

	// Output register: holds one finished result until the consumer takes it.
	logic    out_valid_q;
	result_t out_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign step      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= HARD_MAX_LENGTH;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= (cfg_data > HARD_MAX_LENGTH) ? HARD_MAX_LENGTH : cfg_data;
		end
	end

	nsd_core #(
		.MAX_PREFIX_BYTES(MAX_PREFIX_BYTES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.data_in  (in_byte),
		.limit    (limit_q),
		.res_valid(res_valid),
		.res      (res)
	);

	// The valid flag is control state and is reset; the result payload is not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = out_q.kind;
	assign out_byte       = out_q.data;
	assign message_length = out_q.length;

	a_hold_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !in_ready)
		else $error("input accepted while a result is held");

	a_byte_only_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind != KIND_DATA) |-> out_q.data == '0)
		else $error("nonzero byte on a non-data result");

	a_length_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind != KIND_DONE) |-> out_q.length == '0)
		else $error("nonzero length on a non-complete result");

endmodule
